@@ hdl/pin_pkg.sv @@
package pin_pkg;

    // Table geometry
    localparam int PAL_DEPTH = 256;
    localparam int IDX_W     = $clog2(PAL_DEPTH);
    localparam int CNT_W     = $clog2(PAL_DEPTH + 1);

    // Fixed field widths
    localparam int CH_W          = 8;
    localparam int COLOR_INDEX_W = 8;
    localparam int ENTRY_COUNT_W = 9;
    localparam int MAX_COLORS_W  = 9;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 9;

    // Max channel difference is 255; start value must lose to any real entry
    localparam int DIST_W = 9;
    localparam logic [DIST_W-1:0] DIST_START = DIST_W'(257);

    // Common width for count / limit compares
    localparam int CMP_W = (CNT_W > MAX_COLORS_W) ? CNT_W : MAX_COLORS_W;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_AVOID_ZERO = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_COLORS = 1'd1;

    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } pin_color_t;

    // Search token walking down the cell row
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [IDX_W-1:0]  found_idx;
        logic [DIST_W-1:0] best_dist;
        logic [IDX_W-1:0]  best_idx;
    } pin_token_t;

    // Shared signals seen by every cell
    typedef struct packed {
        pin_color_t       color;
        logic             start;
        logic [CNT_W-1:0] used;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        pin_color_t       wr_data;
    } pin_bcast_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ZERO,
        S_APPEND,
        S_OUT
    } pin_state_t;

    function automatic logic [CH_W-1:0] chan_diff(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ hdl/pin_if.sv @@
interface pin_pix_if;
    import pin_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    output ready);
endinterface

interface pin_res_if;
    import pin_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [COLOR_INDEX_W-1:0] color_index;
    logic                     added;
    logic                     approximated;
    logic [ENTRY_COUNT_W-1:0] entry_count;

    modport source (output valid, output color_index, output added,
                    output approximated, output entry_count, input ready);
    modport sink   (input valid, input color_index, input added,
                    input approximated, input entry_count, output ready);
endinterface

@@ hdl/pin_cell.sv @@
module pin_cell
    import pin_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] idx,
    input  pin_bcast_t       bc,
    input  pin_token_t       tok_in,
    output pin_token_t       tok_out
);

    pin_color_t        entry_reg;
    pin_token_t        tok_reg;
    pin_token_t        tok_next;
    logic              active;
    logic [CH_W-1:0]   d_r;
    logic [CH_W-1:0]   d_g;
    logic [CH_W-1:0]   d_b;
    logic [CH_W-1:0]   d_max;
    logic [DIST_W-1:0] entry_dist;

    // Only entries in [start, used) take part in the search
    assign active = (idx >= IDX_W'(bc.start)) && (CNT_W'(idx) < bc.used);

    always_comb
    begin
        d_r        = chan_diff(bc.color.red,   entry_reg.red);
        d_g        = chan_diff(bc.color.green, entry_reg.green);
        d_b        = chan_diff(bc.color.blue,  entry_reg.blue);
        d_max      = (d_r > d_g) ? d_r : d_g;
        d_max      = (d_b > d_max) ? d_b : d_max;
        entry_dist = DIST_W'(d_max);
    end

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && active)
        begin
            if (!tok_in.found && (entry_reg == bc.color))
            begin
                tok_next.found     = 1'b1;
                tok_next.found_idx = idx;
            end
            // strict less-than keeps the first entry on a tie
            if (entry_dist < tok_in.best_dist)
            begin
                tok_next.best_dist = entry_dist;
                tok_next.best_idx  = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bc.wr_en && (bc.wr_idx == idx))
        begin
            entry_reg <= bc.wr_data;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ hdl/pin_chain.sv @@
module pin_chain
    import pin_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pin_bcast_t bc,
    input  pin_token_t head,
    output pin_token_t tail
);

    pin_token_t tok [0:PAL_DEPTH];

    assign tok[0] = head;

    for (genvar g = 0; g < PAL_DEPTH; g++)
    begin : g_cell
        pin_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (IDX_W'(g)),
            .bc      (bc),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    assign tail = tok[PAL_DEPTH];

endmodule

@@ hdl/palette_insert_nearest.sv @@
// Channel   Dir  Payload                                         Transfer
// pix       in   red, green, blue, alpha (8b each)               valid & ready
// res       out  color_index(8b) added approximated entry_count  valid & ready
// cfg_*     in   cfg_index selects avoid_zero / max_colors       cfg_write high
//
// One item at a time: after the pix transfer the search token walks the cell
// row one cell per cycle; a hit or nearest pick then loads the output
// register from S_OUT, an append passes S_APPEND first, and creating the
// reserved entry zero adds S_ZERO before that. Reset clears control, the
// entry count and the configuration, not the cell entries. A waiting result
// holds S_OUT, so the next pix transfer waits until the output register loads.
module palette_insert_nearest
    import pin_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    pin_pix_if.sink                pix,
    pin_res_if.source              res,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    pin_state_t state_reg;
    pin_state_t state_next;

    // configuration
    logic                    avoid_zero_reg;
    logic [MAX_COLORS_W-1:0] max_colors_reg;

    // item in flight
    pin_color_t       color_reg;
    logic             launch_reg;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] used_next;
    logic [IDX_W-1:0] rslt_idx_reg;
    logic [IDX_W-1:0] rslt_idx_next;
    logic             rslt_added_reg;
    logic             rslt_added_next;
    logic             rslt_approx_reg;
    logic             rslt_approx_next;

    // output register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [COLOR_INDEX_W-1:0] out_idx_reg;
    logic [COLOR_INDEX_W-1:0] out_idx_next;
    logic                     out_added_reg;
    logic                     out_added_next;
    logic                     out_approx_reg;
    logic                     out_approx_next;
    logic [ENTRY_COUNT_W-1:0] out_count_reg;
    logic [ENTRY_COUNT_W-1:0] out_count_next;

    logic             pix_xfer;
    logic             slot_free;
    logic [CMP_W-1:0] limit_x;
    logic [CMP_W-1:0] cap;
    logic             full;
    logic             need_zero;
    logic             room;
    pin_bcast_t       bc;
    pin_token_t       head;
    pin_token_t       tail;

    assign pix.ready = (state_reg == S_IDLE);
    assign pix_xfer  = pix.valid && pix.ready;
    assign slot_free = !out_valid_reg || res.ready;

    // Limit of zero, or above the table, means the whole table
    always_comb
    begin
        limit_x = CMP_W'(max_colors_reg);
        if ((limit_x == '0) || (limit_x > CMP_W'(PAL_DEPTH)))
        begin
            cap = CMP_W'(PAL_DEPTH);
        end
        else
        begin
            cap = limit_x;
        end
    end

    assign full      = (CMP_W'(used_reg) >= cap);
    assign need_zero = avoid_zero_reg && (used_reg == '0);
    assign room      = (used_reg < CNT_W'(PAL_DEPTH));

    // Token enters cell 0 in the cycle after the transfer, once color_reg holds
    always_comb
    begin
        head.valid     = launch_reg;
        head.found     = 1'b0;
        head.found_idx = '0;
        head.best_dist = DIST_START;
        head.best_idx  = IDX_W'(avoid_zero_reg);
    end

    pin_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .bc    (bc),
        .head  (head),
        .tail  (tail)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pix_xfer)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tail.valid)
                begin
                    if (tail.found || full)
                    begin
                        state_next = S_OUT;
                    end
                    else if (need_zero)
                    begin
                        state_next = S_ZERO;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_ZERO:
            begin
                state_next = S_APPEND;
            end
            S_APPEND:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        used_next        = used_reg;
        rslt_idx_next    = rslt_idx_reg;
        rslt_added_next  = rslt_added_reg;
        rslt_approx_next = rslt_approx_reg;
        out_idx_next     = out_idx_reg;
        out_added_next   = out_added_reg;
        out_approx_next  = out_approx_reg;
        out_count_next   = out_count_reg;
        out_valid_next   = out_valid_reg && !res.ready;

        bc.color   = color_reg;
        bc.start   = avoid_zero_reg;
        bc.used    = used_reg;
        bc.wr_en   = 1'b0;
        bc.wr_idx  = '0;
        bc.wr_data = '0;

        unique case (state_reg)
            S_SCAN:
            begin
                if (tail.valid)
                begin
                    // best_idx already holds the start index when nothing was searched
                    rslt_idx_next    = tail.found ? tail.found_idx : tail.best_idx;
                    rslt_added_next  = 1'b0;
                    rslt_approx_next = !tail.found && full;
                end
            end
            S_ZERO:
            begin
                // reserved all-zero entry
                bc.wr_en   = 1'b1;
                bc.wr_idx  = '0;
                bc.wr_data = '0;
                used_next  = CNT_W'(1);
            end
            S_APPEND:
            begin
                if (room)
                begin
                    bc.wr_en        = 1'b1;
                    bc.wr_idx       = IDX_W'(used_reg);
                    bc.wr_data      = color_reg;
                    rslt_idx_next   = IDX_W'(used_reg);
                    rslt_added_next = 1'b1;
                    used_next       = used_reg + CNT_W'(1);
                end
                else
                begin
                    rslt_idx_next = IDX_W'(used_reg - CNT_W'(1));
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_idx_next    = COLOR_INDEX_W'(rslt_idx_reg);
                    out_added_next  = rslt_added_reg;
                    out_approx_next = rslt_approx_reg;
                    out_count_next  = ENTRY_COUNT_W'(used_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            launch_reg     <= 1'b0;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
            avoid_zero_reg <= 1'b0;
            max_colors_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= pix_xfer;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_AVOID_ZERO: avoid_zero_reg <= cfg_data[0];
                    CFG_MAX_COLORS: max_colors_reg <= MAX_COLORS_W'(cfg_data);
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pix_xfer)
        begin
            color_reg.red   <= pix.red;
            color_reg.green <= pix.green;
            color_reg.blue  <= pix.blue;
            color_reg.alpha <= pix.alpha;
        end
        rslt_idx_reg    <= rslt_idx_next;
        rslt_added_reg  <= rslt_added_next;
        rslt_approx_reg <= rslt_approx_next;
        out_idx_reg     <= out_idx_next;
        out_added_reg   <= out_added_next;
        out_approx_reg  <= out_approx_next;
        out_count_reg   <= out_count_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.color_index  = out_idx_reg;
    assign res.added        = out_added_reg;
    assign res.approximated = out_approx_reg;
    assign res.entry_count  = out_count_reg;

endmodule
